// ----- hw/rtl/hpt_pkg.sv -----
// hpt_pkg: shared constants and types for the homogeneous point transform
// no dependencies
`default_nettype none
package hpt_pkg;
    localparam int COORD_W_DEF = 32;
    localparam int COEF_W_DEF  = 16;
    localparam int LANE_BITS   = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int STATUS_W    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd4;

    localparam logic [1:0] MODE_AFFINE = 2'd0;
    localparam logic [1:0] MODE_PERSP  = 2'd1;
    localparam logic [1:0] MODE_FULL   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SAT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO = 2'd2;

    // per-item control that travels beside the data
    typedef struct packed {
        logic persp;
        logic full;
    } t_ctrl;
endpackage
`default_nettype wire

// ----- hw/rtl/hpt_dot.sv -----
// hpt_dot: four-row dot product engine, multiply stage, add stage, round/saturate stage
// depends on hpt_pkg
`default_nettype none
module hpt_dot
    import hpt_pkg::*;
#(
    parameter int COORD_W = COORD_W_DEF,
    parameter int COEF_W  = COEF_W_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_valid,
    input  wire t_ctrl                     i_ctrl,
    input  wire logic [4*64-1:0]           i_rows,
    input  wire logic signed [COORD_W-1:0] i_v [4],
    output logic                           o_valid,
    output t_ctrl                          o_ctrl,
    output logic signed [COORD_W-1:0]      o_q [4],
    output logic [3:0]                     o_sat
);
    localparam int COEF_FRAC = COEF_W - 4;
    localparam int PW = COORD_W + COEF_W;
    localparam int SW = PW + 2;
    localparam int RW = SW - COEF_FRAC;
    // coordinate limits at the rounded width
    localparam logic signed [RW-1:0] R_MAX =
        $signed({{(RW-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}});
    localparam logic signed [RW-1:0] R_MIN = ~R_MAX;

    logic signed [PW-1:0] r_p [4][4];
    logic signed [SW-1:0] r_s [4];
    logic                 r_v1, r_v2, r_v3;
    t_ctrl                r_c1, r_c2, r_c3;
    logic signed [COORD_W-1:0] r_q [4];
    logic [3:0]           r_sat;

    // stage 1: sixteen products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    r_p[r][c] <= PW'($signed(i_rows[64*r+LANE_BITS*c +: COEF_W]))
                                 * PW'(i_v[c]);
                end
            end
        end
    end

    // stage 2: row sums
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 4; r++) begin
                r_s[r] <= SW'(r_p[r][0]) + SW'(r_p[r][1]) + SW'(r_p[r][2])
                          + SW'(r_p[r][3]);
            end
        end
    end

    // stage 3: round half up and saturate
    always_ff @(posedge i_clk) begin
        logic signed [SW-1:0] t;
        logic signed [RW-1:0] rr;
        if (i_en) begin
            for (int r = 0; r < 4; r++) begin
                t  = r_s[r] + (SW'(1) <<< (COEF_FRAC - 1));
                rr = RW'(t >>> COEF_FRAC);
                if (rr > R_MAX) begin
                    r_q[r] <= {1'b0, {(COORD_W-1){1'b1}}};
                    r_sat[r] <= 1'b1;
                end else if (rr < R_MIN) begin
                    r_q[r] <= {1'b1, {(COORD_W-1){1'b0}}};
                    r_sat[r] <= 1'b1;
                end else begin
                    r_q[r] <= COORD_W'(rr);
                    r_sat[r] <= 1'b0;
                end
            end
        end
    end

    // control pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid; r_v2 <= r_v1; r_v3 <= r_v2;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c1 <= i_ctrl; r_c2 <= r_c1; r_c3 <= r_c2;
        end
    end

    assign o_valid = r_v3;
    assign o_ctrl  = r_c3;
    assign o_q     = r_q;
    assign o_sat   = r_sat;
endmodule
`default_nettype wire

// ----- hw/rtl/hpt_div.sv -----
// hpt_div: pipelined restoring divider for the three perspective quotients plus result select
// depends on hpt_pkg
`default_nettype none
module hpt_div
    import hpt_pkg::*;
#(
    parameter int COORD_W = COORD_W_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_valid,
    input  wire t_ctrl                     i_ctrl,
    input  wire logic signed [COORD_W-1:0] i_q [4],
    input  wire logic [3:0]                i_sat,
    output logic                           o_valid,
    output logic [4*COORD_W-1:0]           o_data,
    output logic [STATUS_W-1:0]            o_status
);
    localparam int FRAC  = COORD_W / 2;
    localparam int STEPS = COORD_W + FRAC;
    localparam int QW    = COORD_W + 1;
    localparam int RMW   = COORD_W + 1;

    // per-stage state: remainder, quotient, overflow, dividend bits left
    logic [RMW-1:0]     r_rem  [STEPS+1][3];
    logic [QW-1:0]      r_quo  [STEPS+1][3];
    logic               r_ovf  [STEPS+1][3];
    logic [COORD_W-1:0] r_num  [STEPS+1][3];
    logic               r_neg  [STEPS+1][3];
    logic [COORD_W-1:0] r_den  [STEPS+1];
    logic signed [COORD_W-1:0] r_raw [STEPS+1][4];
    logic               r_anysat [STEPS+1];
    t_ctrl              r_ctl  [STEPS+1];
    logic [STEPS:0]     r_vld;

    logic [COORD_W-1:0] abs_d;
    assign abs_d = i_q[3][COORD_W-1] ? COORD_W'(-i_q[3]) : COORD_W'(i_q[3]);

    // stage 0: magnitudes and signs
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_rem[0][k] <= '0;
                r_quo[0][k] <= '0;
                r_ovf[0][k] <= 1'b0;
                r_num[0][k] <= i_q[k][COORD_W-1] ? COORD_W'(-i_q[k]) : COORD_W'(i_q[k]);
                r_neg[0][k] <= i_q[k][COORD_W-1] ^ i_q[3][COORD_W-1];
            end
            r_den[0]     <= abs_d;
            r_raw[0]     <= i_q;
            // the fourth row only counts when it is part of the result
            r_anysat[0]  <= (|i_sat[2:0]) | (i_sat[3] & (i_ctrl.full | i_ctrl.persp));
            r_ctl[0]     <= i_ctrl;
        end
    end

    // one quotient bit per stage
    for (genvar s = 0; s < STEPS; s++) begin : g_step
        always_ff @(posedge i_clk) begin
            logic [RMW-1:0] t;
            logic           qb;
            logic [QW-1:0]  nq;
            if (i_en) begin
                for (int k = 0; k < 3; k++) begin
                    t = {r_rem[s][k][RMW-2:0], (s < COORD_W) ? r_num[s][k][COORD_W-1] : 1'b0};
                    qb = (t >= RMW'(r_den[s]));
                    r_rem[s+1][k] <= qb ? t - RMW'(r_den[s]) : t;
                    r_num[s+1][k] <= {r_num[s][k][COORD_W-2:0], 1'b0};
                    r_neg[s+1][k] <= r_neg[s][k];
                    if (!r_ovf[s][k]) begin
                        nq = {r_quo[s][k][QW-2:0], qb};
                        r_quo[s+1][k] <= nq;
                        r_ovf[s+1][k] <= (nq > (QW'(1) << (COORD_W - 1))) ||
                                         r_quo[s][k][QW-1];
                    end else begin
                        r_quo[s+1][k] <= r_quo[s][k];
                        r_ovf[s+1][k] <= 1'b1;
                    end
                end
                r_den[s+1]    <= r_den[s];
                r_raw[s+1]    <= r_raw[s];
                r_anysat[s+1] <= r_anysat[s];
                r_ctl[s+1]    <= r_ctl[s];
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[STEPS-1:0], i_valid};
        end
    end

    // final limit and result select
    logic [COORD_W-1:0] r_out [4];
    logic [STATUS_W-1:0] r_st;
    logic r_ov;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_vld[STEPS];
        end
    end
    always_ff @(posedge i_clk) begin
        logic [QW-1:0] lim, q;
        logic sat;
        logic [COORD_W-1:0] res [4];
        logic [STATUS_W-1:0] st;
        if (i_en) begin
            sat = r_anysat[STEPS];
            st  = ST_OK;
            for (int k = 0; k < 4; k++) res[k] = r_raw[STEPS][k];
            if (r_ctl[STEPS].full) begin
                // full vector: rounded products as they are
            end else if (r_ctl[STEPS].persp) begin
                if (r_raw[STEPS][3] == '0) begin
                    for (int k = 0; k < 4; k++) res[k] = '0;
                    st = ST_ZERO;
                end else begin
                    for (int k = 0; k < 3; k++) begin
                        lim = r_neg[STEPS][k] ? (QW'(1) << (COORD_W - 1))
                                              : (QW'(1) << (COORD_W - 1)) - QW'(1);
                        q = r_quo[STEPS][k];
                        if (r_ovf[STEPS][k] || q > lim) begin
                            q = lim;
                            sat = 1'b1;
                        end
                        res[k] = r_neg[STEPS][k] ? COORD_W'(-q) : COORD_W'(q);
                    end
                end
            end else begin
                res[3] = COORD_W'(1) << FRAC;
            end
            if (st != ST_ZERO && sat)
                st = ST_SAT;
            for (int k = 0; k < 4; k++) r_out[k] <= res[k];
            r_st <= st;
        end
    end

    assign o_valid  = r_ov;
    assign o_data   = {r_out[3], r_out[2], r_out[1], r_out[0]};
    assign o_status = r_st;
endmodule
`default_nettype wire

// ----- hw/rtl/homogeneous_point_transform_core.sv -----
// homogeneous_point_transform_core: top level, config registers, stream ports and stall control
// depends on hpt_pkg, hpt_dot, hpt_div
`default_nettype none
// One point enters per cycle and one result leaves per cycle while the output
// is not held. Each point passes the multiply, add and round stages of the
// dot product, then a magnitude and sign stage, then the radix-2 divider of
// one quotient bit per stage, then result select. The
// whole pipeline advances together; a stalled output freezes every stage.
// Input tdata: px, py, pz, pw from the lowest bit up. Output tdata: qx, qy,
// qz, qw; output tuser: status. Write the matrix rows and mode only while idle.
module homogeneous_point_transform_core
    import hpt_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_W_DEF,
    parameter int COEF_WIDTH  = COEF_W_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [4*COORD_WIDTH-1:0] s_axis_tdata,  // px, py, pz, pw
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic [4*COORD_WIDTH-1:0]      m_axis_tdata,  // qx, qy, qz, qw
    output logic [STATUS_W-1:0]           m_axis_tuser,  // status
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [63:0]              i_cfg_data
);
    localparam int FRAC = COORD_WIDTH / 2;
    localparam logic [63:0] ONE = 64'(1) << (COEF_WIDTH - 4);

    logic [63:0] r_row [4];
    logic [1:0]  r_mode;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= ONE;
            r_row[1] <= ONE << LANE_BITS;
            r_row[2] <= ONE << (2 * LANE_BITS);
            r_row[3] <= ONE << (3 * LANE_BITS);
            r_mode   <= MODE_AFFINE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ROW0: r_row[0] <= i_cfg_data;
                REG_ROW1: r_row[1] <= i_cfg_data;
                REG_ROW2: r_row[2] <= i_cfg_data;
                REG_ROW3: r_row[3] <= i_cfg_data;
                REG_MODE: r_mode   <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    // pipeline advances unless the output word is held
    logic en;
    assign en = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = en;

    logic signed [COORD_WIDTH-1:0] v [4];
    t_ctrl ctl;
    always_comb begin
        for (int k = 0; k < 3; k++) v[k] = s_axis_tdata[k*COORD_WIDTH +: COORD_WIDTH];
        v[3] = r_mode[1] ? s_axis_tdata[3*COORD_WIDTH +: COORD_WIDTH]
                         : COORD_WIDTH'(1) << FRAC;
        ctl.full  = r_mode[1];
        ctl.persp = (r_mode == MODE_PERSP);
    end

    logic                          d_valid;
    t_ctrl                         d_ctrl;
    logic signed [COORD_WIDTH-1:0] d_q [4];
    logic [3:0]                    d_sat;

    hpt_dot #(.COORD_W(COORD_WIDTH), .COEF_W(COEF_WIDTH)) u_dot (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(s_axis_tvalid), .i_ctrl(ctl),
        .i_rows({r_row[3], r_row[2], r_row[1], r_row[0]}), .i_v(v),
        .o_valid(d_valid), .o_ctrl(d_ctrl), .o_q(d_q), .o_sat(d_sat)
    );

    hpt_div #(.COORD_W(COORD_WIDTH)) u_div (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(d_valid), .i_ctrl(d_ctrl),
        .i_q(d_q), .i_sat(d_sat),
        .o_valid(m_axis_tvalid), .o_data(m_axis_tdata), .o_status(m_axis_tuser)
    );

`ifndef SYNTH
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser != 2'd3)
        else $error("bad status code");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_ZERO |-> m_axis_tdata == '0)
        else $error("zero denominator result not cleared");
`endif
endmodule
`default_nettype wire
